// ===== src/cdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque package
// Shared request and result types, operation and status codes, and the
// memory command bundle used between the controller and the word store.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Operation codes carried in the op field of a request.
  typedef enum logic [2:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_POP_REAR   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DUMP       = 3'd4
  } cdq_op_e;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  // One request.
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value_in;
  } cdq_in_t;

  // One result.
  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [3:0]         fill_count;
    logic               last;
  } cdq_out_t;

  // Memory command strobes from the controller.
  typedef struct packed {
    logic we;
    logic re;
  } cdq_mem_cmd_t;

endpackage

// ===== src/cdq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque word store
// Single-port synchronous memory of DEPTH 32-bit words with a registered
// read port. Contents are not reset.
// ----------------------------------------------------------------------------
module cdq_ram
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk_i,
  input  cdq_mem_cmd_t               cmd_i,
  input  logic [$clog2(DEPTH)-1:0]   addr_i,
  input  logic signed [31:0]         wdata_i,
  output logic signed [31:0]         rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (cmd_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque controller
// Keeps the front index, rear index and element count, decodes requests,
// drives the word store and holds the result register.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cdq_in_t                    in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cdq_out_t                   out_data_o,
  output cdq_mem_cmd_t               mem_cmd_o,
  output logic [$clog2(DEPTH)-1:0]   mem_addr_o,
  output logic signed [31:0]         mem_wdata_o,
  input  logic signed [31:0]         mem_rdata_i
);

  localparam int IdxW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  // State codes: idle takes requests, drain returns words read from the store.
  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] rear_q, rear_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            out_valid_q, out_valid_d;
  cdq_out_t        out_q, out_d;

  logic out_free;
  logic in_acc;
  logic is_full;
  logic is_empty;

  // Index steps wrap modulo DEPTH in both directions.
  function automatic logic [IdxW-1:0] step_up(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] step_down(input logic [IdxW-1:0] idx);
    return (idx == '0) ? IdxW'(DEPTH - 1) : idx - 1'b1;
  endfunction

  // The reported fill count keeps the low four bits of the element count.
  function automatic logic [3:0] to_fill(input logic [CntW-1:0] c);
    logic [CntW+3:0] ext;
    ext = {4'b0, c};
    return ext[3:0];
  endfunction

  // Handshake: one request at a time, taken only when the result register
  // is free or is being emptied in this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_full    = (cnt_q == CntW'(DEPTH));
  assign is_empty   = (cnt_q == '0);

  // Next-state logic for indices, count, sequencer and result register.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    remain_d    = remain_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_cmd_o   = '0;
    mem_addr_o  = ptr_q;
    mem_wdata_o = in_data_i.value_in;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data_i.op)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
              out_valid_d         = 1'b1;
              out_d.value_out     = '0;
              out_d.last          = 1'b1;
              if (is_full) begin
                out_d.status     = ST_FULL;
                out_d.fill_count = to_fill(cnt_q);
              end else begin
                mem_cmd_o.we = 1'b1;
                if (in_data_i.op == OP_PUSH_REAR) begin
                  rear_d     = step_up(rear_q);
                  mem_addr_o = step_up(rear_q);
                end else begin
                  front_d    = step_down(front_q);
                  mem_addr_o = step_down(front_q);
                end
                cnt_d            = cnt_q + 1'b1;
                out_d.status     = ST_OK;
                out_d.fill_count = to_fill(cnt_d);
              end
            end
            OP_POP_REAR, OP_POP_FRONT: begin
              if (is_empty) begin
                out_valid_d      = 1'b1;
                out_d.value_out  = '0;
                out_d.status     = ST_EMPTY;
                out_d.fill_count = to_fill(cnt_q);
                out_d.last       = 1'b1;
              end else begin
                mem_cmd_o.re = 1'b1;
                if (in_data_i.op == OP_POP_REAR) begin
                  mem_addr_o = rear_q;
                  rear_d     = step_down(rear_q);
                end else begin
                  mem_addr_o = front_q;
                  front_d    = step_up(front_q);
                end
                cnt_d    = cnt_q - 1'b1;
                remain_d = CntW'(1);
                state_d  = ST_DRAIN;
              end
            end
            OP_DUMP: begin
              if (is_empty) begin
                out_valid_d      = 1'b1;
                out_d.value_out  = '0;
                out_d.status     = ST_EMPTY;
                out_d.fill_count = to_fill(cnt_q);
                out_d.last       = 1'b1;
              end else begin
                mem_cmd_o.re = 1'b1;
                mem_addr_o   = front_q;
                ptr_d        = step_up(front_q);
                remain_d     = cnt_q;
                state_d      = ST_DRAIN;
              end
            end
            default: begin
              // Unused op codes are dropped without a result.
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // Hand over the word held in the store read register and, unless it is the last, fetch the next one.
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.value_out  = mem_rdata_i;
          out_d.status     = ST_OK;
          out_d.fill_count = to_fill(cnt_q);
          out_d.last       = (remain_q == CntW'(1));
          if (remain_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            mem_cmd_o.re = 1'b1;
            mem_addr_o   = ptr_q;
            ptr_d        = step_up(ptr_q);
            remain_d     = remain_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      rear_q      <= IdxW'(DEPTH - 1);
      cnt_q       <= '0;
      ptr_q       <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/circular_deque_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular deque top level
// Double-ended queue of DEPTH 32-bit words in a circular on-chip store.
// A push or an error result goes into the result register; a pop result
// passes the store read register, then the result register; a dump gives
// its words the same way, one word per cycle while the output is not
// stalled, paced by the single store read port. The next request is taken
// once the last result of the current one is registered. Reset clears
// indices, count and the result valid; the store contents are not cleared.
// ----------------------------------------------------------------------------
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cdq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cdq_out_t out_data_o
);

  localparam int IdxW = $clog2(DEPTH);

  cdq_mem_cmd_t       mem_cmd;
  logic [IdxW-1:0]    mem_addr;
  logic signed [31:0] mem_wdata;
  logic signed [31:0] mem_rdata;

  // Controller with indices, count and result register.
  cdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_cmd_o   (mem_cmd),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Word store.
  cdq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // The store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_cmd.we && mem_cmd.re))
    else $error("store read and write in the same cycle");

  // A store write only happens for a request taken in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_cmd.we |-> (in_valid_i && !in_stall_o))
    else $error("store write without an accepted request");

  // Error results are single, final and carry a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_OK))
      |-> (out_data_o.last && (out_data_o.value_out == '0)))
    else $error("error result is not a final zero word");

  // A full error reports a fill count equal to the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == ST_FULL))
      |-> (out_data_o.fill_count == 4'(DEPTH)))
    else $error("full error with wrong fill count");

endmodule
